/* rtl/chbd_pkg.sv */
// Shared types and constants for the canonical Huffman bit decoder.
package chbd_pkg;

  typedef enum logic [1:0] {
    FUNC_COUNT  = 2'd0,
    FUNC_SYMBOL = 2'd1,
    FUNC_DECODE = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK           = 2'd0,
    ERR_INVALID_CODE = 2'd1,
    ERR_LENGTH       = 2'd2,
    ERR_OVERSUB      = 2'd3
  } err_t;

  localparam int HDR_BYTES = 19;
  localparam int LEN_W     = 5;
  localparam int VAL_W     = 8;
  localparam int ACC_W     = 16;
  localparam int SEG_W     = 16;
  localparam int FC_W      = 17;
  localparam int FI_W      = 9;
  localparam int IDX_W     = 10;
  localparam int TOTAL_W   = 12;

  // Count write request and table lookup select.
  typedef struct packed {
    logic              sel;
    logic              en;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  val;
  } tbl_req_t;

  // Lookup answer for the current code prefix.
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic               more;
    logic               beyond;
    logic               ovf;
    logic [TOTAL_W-1:0] total;
  } tbl_lk_t;

endpackage

/* rtl/chbd_table.sv */
// Code-length table with incrementally maintained canonical first codes and lookup.
module chbd_table #(
  parameter int MAX_CODE_LEN = 16,
  parameter int MAX_SYMBOLS  = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chbd_pkg::tbl_req_t         req,
  input  logic [chbd_pkg::LEN_W-1:0] bt,
  input  logic [chbd_pkg::ACC_W-1:0] p,
  output chbd_pkg::tbl_lk_t          lk
);

  localparam int LEN_W   = chbd_pkg::LEN_W;
  localparam int VAL_W   = chbd_pkg::VAL_W;
  localparam int FC_W    = chbd_pkg::FC_W;
  localparam int FI_W    = chbd_pkg::FI_W;
  localparam int IDX_W   = chbd_pkg::IDX_W;
  localparam int TOTAL_W = chbd_pkg::TOTAL_W;
  localparam int ACC_W   = chbd_pkg::ACC_W;
  localparam int CL_W    = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int KR_W    = VAL_W + MAX_CODE_LEN;
  localparam int CMP_W   = (KR_W > ACC_W) ? KR_W : ACC_W;

  logic [VAL_W-1:0]   cnt_r   [MAX_CODE_LEN];
  logic [FC_W-1:0]    fc_r    [MAX_CODE_LEN];
  logic [FI_W-1:0]    fi_r    [MAX_CODE_LEN];
  logic [VAL_W-1:0]   cnt_nxt [MAX_CODE_LEN];
  logic [FC_W-1:0]    fc_nxt  [MAX_CODE_LEN];
  logic [FI_W-1:0]    fi_nxt  [MAX_CODE_LEN];
  logic [KR_W-1:0]    kr_r, kr_nxt;
  logic [TOTAL_W-1:0] tot_r, tot_nxt;

  logic [LEN_W-1:0]   rd_pos;
  logic               rd_ok;
  logic [VAL_W-1:0]   rd_cnt;
  logic [FC_W-1:0]    rd_fc;
  logic [FI_W-1:0]    rd_fi;

  logic               clr;
  logic [LEN_W-1:0]   wr_pos;
  logic [VAL_W-1:0]   old_cnt;
  logic [LEN_W-1:0]   kr_sh;

  logic [LEN_W-1:0]   cur_len;
  logic [FC_W-1:0]    diff;
  logic [MAX_CODE_LEN-1:0] longer_nz;
  logic [KR_W-1:0]    bound;

  // One read port: the write position on a count write, the prefix length otherwise.
  assign rd_pos = req.sel ? (req.len - LEN_W'(1)) : bt;
  assign rd_ok  = (rd_pos < LEN_W'(MAX_CODE_LEN));
  assign rd_cnt = rd_ok ? cnt_r[rd_pos[CL_W-1:0]] : '0;
  assign rd_fc  = rd_ok ? fc_r[rd_pos[CL_W-1:0]]  : '0;
  assign rd_fi  = rd_ok ? fi_r[rd_pos[CL_W-1:0]]  : '0;

  // Length 1 opens a new table: start from an all-zero table.
  assign clr     = (req.len == LEN_W'(1));
  assign wr_pos  = req.len - LEN_W'(1);
  assign old_cnt = clr ? '0 : rd_cnt;
  assign kr_sh   = LEN_W'(MAX_CODE_LEN - 1) - wr_pos;

  always_comb begin
    logic [LEN_W-1:0] sh;
    logic [FC_W-1:0]  base_fc;
    logic [FI_W-1:0]  base_fi;
    sh = '0;
    for (int k = 0; k < MAX_CODE_LEN; k++) begin
      base_fc    = clr ? '0 : fc_r[k];
      base_fi    = clr ? '0 : fi_r[k];
      cnt_nxt[k] = clr ? '0 : cnt_r[k];
      fc_nxt[k]  = base_fc;
      fi_nxt[k]  = base_fi;
      if (LEN_W'(k) == wr_pos) begin
        cnt_nxt[k] = req.val;
      end
      // Shift the delta into every longer length.
      if (LEN_W'(k) > wr_pos) begin
        sh        = LEN_W'(k) - wr_pos;
        fc_nxt[k] = base_fc + (FC_W'(req.val) << sh) - (FC_W'(old_cnt) << sh);
        fi_nxt[k] = base_fi + FI_W'(req.val) - FI_W'(old_cnt);
      end
    end
    kr_nxt  = (clr ? '0 : kr_r) + (KR_W'(req.val) << kr_sh) - (KR_W'(old_cnt) << kr_sh);
    tot_nxt = (clr ? '0 : tot_r) + TOTAL_W'(req.val) - TOTAL_W'(old_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_CODE_LEN; k++) begin
        cnt_r[k] <= '0;
        fc_r[k]  <= '0;
        fi_r[k]  <= '0;
      end
      kr_r  <= '0;
      tot_r <= '0;
    end else if (req.en) begin
      for (int k = 0; k < MAX_CODE_LEN; k++) begin
        cnt_r[k] <= cnt_nxt[k];
        fc_r[k]  <= fc_nxt[k];
        fi_r[k]  <= fi_nxt[k];
      end
      kr_r  <= kr_nxt;
      tot_r <= tot_nxt;
    end
  end

  // Lookup of the extended prefix p of length bt + 1.
  assign cur_len = bt + LEN_W'(1);
  assign diff    = FC_W'(p) - rd_fc;

  always_comb begin
    for (int k = 0; k < MAX_CODE_LEN; k++) begin
      longer_nz[k] = (cnt_r[k] != '0) && (LEN_W'(k) >= cur_len);
    end
  end

  // Kraft sum at the longest length, scaled down: the last code's prefix at this length.
  assign bound = (kr_r - KR_W'(1)) >> (LEN_W'(MAX_CODE_LEN) - cur_len);

  assign lk.hit    = (rd_cnt != '0) && (FC_W'(p) >= rd_fc) && (diff < FC_W'(rd_cnt));
  assign lk.idx    = IDX_W'(rd_fi) + IDX_W'(diff[VAL_W-1:0]);
  assign lk.more   = |longer_nz;
  assign lk.beyond = (CMP_W'(p) > CMP_W'(bound));
  assign lk.ovf    = (kr_r > (KR_W'(1) << MAX_CODE_LEN)) ||
                     (tot_r > TOTAL_W'(MAX_SYMBOLS));
  assign lk.total  = tot_r;

endmodule

/* rtl/canonical_huffman_bit_decoder.sv */
// Top level of the canonical Huffman bit decoder.
// Loads one JPEG style Huffman table (counts for lengths 1 to MAX_CODE_LEN, a
// count for length 1 starting a new table, then symbols in table order) and
// decodes one code bit per request. Every request gives exactly one result,
// registered first with the symbol memory's read and then in the output
// register. The block takes one request per cycle while the result side does
// not stall; table writes update the canonical first codes of all lengths in
// the same cycle, so a decode bit may follow a load directly.
// The symbol memory needs no clearing after reset.
module canonical_huffman_bit_decoder #(
  parameter int MAX_CODE_LEN = 16,
  parameter int MAX_SYMBOLS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_code_length,
  input  logic [7:0]  in_entry_value,
  input  logic        in_code_bit,
  input  logic [15:0] in_segment_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol,
  output logic        out_symbol_valid,
  output logic [1:0]  out_error_code
);

  localparam int LEN_W = chbd_pkg::LEN_W;
  localparam int ACC_W = chbd_pkg::ACC_W;
  localparam int IDX_W = chbd_pkg::IDX_W;
  localparam int SEG_W = chbd_pkg::SEG_W;
  localparam int CHK_W = SEG_W + 1;
  localparam int SA_W  = $clog2(MAX_SYMBOLS);
  localparam int SL_W  = $clog2(MAX_SYMBOLS + 1);

  chbd_pkg::func_t    func;
  chbd_pkg::tbl_req_t req;
  chbd_pkg::tbl_lk_t  lk;

  logic               accept;
  logic               out_load;
  logic               s1_move;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [LEN_W-1:0]   bt_r, bt_nxt;
  logic [SL_W-1:0]    loaded_r, loaded_nxt;
  logic [ACC_W-1:0]   prefix;
  chbd_pkg::err_t     err_nxt;
  logic               symv_nxt;
  logic               st_wr;
  logic               rd_en;

  logic               s1_valid_r;
  logic               s1_symv_r;
  chbd_pkg::err_t     s1_err_r;

  logic [7:0]         store [MAX_SYMBOLS];
  logic [7:0]         mem_q_r;

  logic               out_valid_r;
  logic [7:0]         out_symbol_r;
  logic               out_symbol_valid_r;
  chbd_pkg::err_t     out_error_code_r;

  assign func     = chbd_pkg::func_t'(in_func);
  assign out_load = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign accept   = in_valid && !in_stall;

  assign req.sel = (func == chbd_pkg::FUNC_COUNT);
  assign req.en  = accept && req.sel && (in_code_length != '0) &&
                   (in_code_length <= LEN_W'(MAX_CODE_LEN));
  assign req.len = in_code_length;
  assign req.val = in_entry_value;

  assign prefix = {acc_r[ACC_W-2:0], in_code_bit};

  chbd_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .bt    (bt_r),
    .p     (prefix),
    .lk    (lk)
  );

  always_comb begin
    acc_nxt    = '0;
    bt_nxt     = '0;
    loaded_nxt = loaded_r;
    err_nxt    = chbd_pkg::ERR_OK;
    symv_nxt   = 1'b0;
    st_wr      = 1'b0;
    rd_en      = 1'b0;
    case (func)
      chbd_pkg::FUNC_COUNT: begin
        if (req.en && (in_code_length == LEN_W'(1))) begin
          loaded_nxt = '0;
        end
      end
      chbd_pkg::FUNC_SYMBOL: begin
        if (loaded_r < SL_W'(MAX_SYMBOLS)) begin
          st_wr      = 1'b1;
          loaded_nxt = loaded_r + SL_W'(1);
        end
      end
      chbd_pkg::FUNC_CHECK: begin
        if (lk.ovf) begin
          err_nxt = chbd_pkg::ERR_OVERSUB;
        end else if (CHK_W'(lk.total) + CHK_W'(chbd_pkg::HDR_BYTES) !=
                     CHK_W'(in_segment_length)) begin
          err_nxt = chbd_pkg::ERR_LENGTH;
        end
      end
      chbd_pkg::FUNC_DECODE: begin
        if (lk.ovf) begin
          err_nxt = chbd_pkg::ERR_OVERSUB;
        end else if (lk.hit) begin
          if (lk.idx < IDX_W'(loaded_r)) begin
            symv_nxt = 1'b1;
            rd_en    = 1'b1;
          end else begin
            err_nxt = chbd_pkg::ERR_INVALID_CODE;
          end
        end else if (!lk.more || lk.beyond) begin
          err_nxt = chbd_pkg::ERR_INVALID_CODE;
        end else begin
          // Still a prefix of some longer code: hold it and wait for the next bit.
          acc_nxt = prefix;
          bt_nxt  = bt_r + LEN_W'(1);
        end
      end
      default: begin
        err_nxt = chbd_pkg::ERR_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      bt_r       <= '0;
      loaded_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        acc_r    <= acc_nxt;
        bt_r     <= bt_nxt;
        loaded_r <= loaded_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_symv_r <= symv_nxt;
      s1_err_r  <= err_nxt;
    end
  end

  // Symbol memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (accept && st_wr) begin
      store[loaded_r[SA_W-1:0]] <= in_entry_value;
    end
    if (accept && rd_en) begin
      mem_q_r <= store[lk.idx[SA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_symbol_r       <= s1_symv_r ? mem_q_r : '0;
      out_symbol_valid_r <= s1_symv_r;
      out_error_code_r   <= s1_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_symbol_valid = out_symbol_valid_r;
  assign out_error_code   = out_error_code_r;

endmodule

/* rtl/chbd_checker.sv */
// Port-level checks for the canonical Huffman bit decoder, bound to the top level.
module chbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_symbol,
  input logic        out_symbol_valid,
  input logic [1:0]  out_error_code
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) &&
      $stable(out_symbol_valid) && $stable(out_error_code))
    else $error("result changed while stalled");

  // Input backs up only when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // A decoded symbol carries no error.
  a_sym_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_valid |-> out_error_code == chbd_pkg::ERR_OK)
    else $error("symbol with error code");

  // Without a symbol the symbol field is zero.
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_symbol_valid |-> out_symbol == 8'd0)
    else $error("nonzero symbol without symbol_valid");

  // A request accepted with no result shown and no stall reaches out_valid via the stage and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !out_stall |=> ##1 out_valid)
    else $error("result missing after request");

endmodule

bind canonical_huffman_bit_decoder chbd_checker u_chbd_checker (.*);
